// File: design/tes_pkg.sv
// Package for the text encoding sniffer: verdict codes, byte-order-mark
// bytes and the reset value of the window register. No dependencies.
package tes_pkg;

    typedef logic [2:0] t_enc;
    typedef logic [1:0] t_bom;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic [15:0] WINDOW_RESET   = 16'd8192;
    localparam logic [16:0] BYTE_COUNT_MAX = 17'h1FFFF;

    localparam t_enc ENC_UNKNOWN = 3'd0;
    localparam t_enc ENC_ASCII   = 3'd1;
    localparam t_enc ENC_UTF8    = 3'd2;
    localparam t_enc ENC_UTF16LE = 3'd3;
    localparam t_enc ENC_UTF16BE = 3'd4;
    localparam t_enc ENC_LEGACY  = 3'd5;
    localparam t_enc ENC_BINARY  = 3'd6;

    localparam t_bom BOM_NONE  = 2'd0;
    localparam t_bom BOM_UTF16 = 2'd2;
    localparam t_bom BOM_UTF8  = 2'd3;

    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    localparam logic [20:0] CP_MIN_2   = 21'h000080;
    localparam logic [20:0] CP_MIN_3   = 21'h000800;
    localparam logic [20:0] CP_MIN_4   = 21'h010000;
    localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    localparam logic [7:0] CTL_LIMIT  = 8'h20;
    localparam int         CTL_RATIO  = 100;

endpackage

// File: design/text_encoding_sniffer.sv
// Text encoding sniffer: per-byte statistics and UTF-8 validation, then a
// registered verdict stage and an output register. Depends on tes_pkg.
// o_out_valid rises once the last byte or empty-file item has been accepted and its
// state has passed the snapshot register, then the output register. Throughput: one
// byte per cycle; input stalls only while a verdict waits behind a stalled output.
// Reset (synchronous, active low): all stream state cleared, window = 8192.
module text_encoding_sniffer #(
    parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_empty_file,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tes_pkg::t_enc     o_encoding_code,
    output tes_pkg::t_bom     o_bom_length
);
    import tes_pkg::*;

    localparam int CMP_W = (COUNT_BITS + 7 > 18) ? COUNT_BITS + 7 : 18;

    // stream state
    logic [15:0]           r_window;
    logic [16:0]           r_byte_count, n_byte_count;
    logic [7:0]            r_lead [3];
    logic [7:0]            n_lead [3];
    logic [COUNT_BITS-1:0] r_zeros_even, n_zeros_even;
    logic [COUNT_BITS-1:0] r_zeros_odd, n_zeros_odd;
    logic [COUNT_BITS-1:0] r_ctl_count, n_ctl_count;
    logic                  r_high_seen, n_high_seen;
    logic [1:0]            r_cont_remaining, n_cont_remaining;
    logic [1:0]            r_seq_length, n_seq_length;
    logic [20:0]           r_code_accum, n_code_accum;
    logic                  r_pending_bad, n_pending_bad;
    logic                  r_utf8_invalid, n_utf8_invalid;
    logic                  r_window_cut, n_window_cut;

    // verdict snapshot
    logic                  r_snap_valid;
    logic                  r_snap_empty;
    logic [16:0]           r_snap_bc;
    logic [7:0]            r_snap_lead [3];
    logic [COUNT_BITS-1:0] r_snap_ze, r_snap_zo, r_snap_ctl;
    logic                  r_snap_high, r_snap_invalid, r_snap_open, r_snap_cut;

    // output register
    logic                  r_out_valid;
    t_enc                  r_enc;
    t_bom                  r_bom;

    logic w_out_load, w_snap_adv, w_in_acc, w_done;
    logic w_in_win, w_is_ctl, w_pb;
    logic [1:0] w_cont_dec;
    t_enc w_enc;
    t_bom w_bom;

    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_snap_adv = r_snap_valid && w_out_load;
    assign o_in_stall = r_snap_valid && !w_snap_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_done     = w_in_acc && (i_last_byte || i_empty_file);

    assign w_in_win = r_byte_count < {1'b0, r_window};
    assign w_is_ctl = (i_data_byte < CTL_LIMIT) && (i_data_byte != 8'h09)
                   && (i_data_byte != 8'h0A) && (i_data_byte != 8'h0D)
                   && (i_data_byte != 8'h0C);
    assign w_cont_dec = r_cont_remaining - 2'd1;

    // per-byte state update
    always_comb begin
        n_byte_count     = r_byte_count;
        n_lead           = r_lead;
        n_zeros_even     = r_zeros_even;
        n_zeros_odd      = r_zeros_odd;
        n_ctl_count      = r_ctl_count;
        n_high_seen      = r_high_seen;
        n_cont_remaining = r_cont_remaining;
        n_seq_length     = r_seq_length;
        n_code_accum     = r_code_accum;
        n_pending_bad    = r_pending_bad;
        n_utf8_invalid   = r_utf8_invalid;
        n_window_cut     = r_window_cut;
        w_pb             = r_pending_bad;

        if (r_byte_count < 17'd3) begin
            n_lead[r_byte_count[1:0]] = i_data_byte;
        end

        if (w_in_win) begin
            if (i_data_byte == 8'h00) begin
                if (r_byte_count[0]) begin
                    if (!(&r_zeros_odd)) n_zeros_odd = r_zeros_odd + 1'b1;
                end else begin
                    if (!(&r_zeros_even)) n_zeros_even = r_zeros_even + 1'b1;
                end
            end
            if (w_is_ctl && !(&r_ctl_count)) begin
                n_ctl_count = r_ctl_count + 1'b1;
            end
            if (i_data_byte[7]) begin
                n_high_seen = 1'b1;
            end

            if (!r_utf8_invalid) begin
                if (r_cont_remaining == 2'd0) begin
                    if (i_data_byte[7]) begin
                        n_pending_bad = 1'b0;
                        if (i_data_byte[7:5] == 3'b110) begin
                            n_seq_length     = 2'd1;
                            n_cont_remaining = 2'd1;
                            n_code_accum     = {16'd0, i_data_byte[4:0]};
                        end else if (i_data_byte[7:4] == 4'b1110) begin
                            n_seq_length     = 2'd2;
                            n_cont_remaining = 2'd2;
                            n_code_accum     = {17'd0, i_data_byte[3:0]};
                        end else if (i_data_byte[7:3] == 5'b11110) begin
                            n_seq_length     = 2'd3;
                            n_cont_remaining = 2'd3;
                            n_code_accum     = {18'd0, i_data_byte[2:0]};
                        end else begin
                            n_utf8_invalid = 1'b1;
                            n_pending_bad  = r_pending_bad;
                        end
                    end
                end else begin
                    if (i_data_byte[7:6] != 2'b10) w_pb = 1'b1;
                    n_pending_bad    = w_pb;
                    n_code_accum     = {r_code_accum[14:0], i_data_byte[5:0]};
                    n_cont_remaining = w_cont_dec;
                    if (w_cont_dec == 2'd0) begin
                        // sequence complete: reject bad bytes, overlong forms,
                        // surrogates and values beyond the Unicode range
                        if (w_pb
                            || (r_seq_length == 2'd1 && n_code_accum < CP_MIN_2)
                            || (r_seq_length == 2'd2 && n_code_accum < CP_MIN_3)
                            || (r_seq_length == 2'd3 && n_code_accum < CP_MIN_4)
                            || (n_code_accum >= CP_SUR_LO && n_code_accum <= CP_SUR_HI)
                            || (n_code_accum > CP_MAX)) begin
                            n_utf8_invalid = 1'b1;
                        end
                        n_pending_bad = 1'b0;
                    end
                end
            end
        end else begin
            n_window_cut = 1'b1;
        end

        if (r_byte_count != BYTE_COUNT_MAX) begin
            n_byte_count = r_byte_count + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_byte_count     <= '0;
            r_lead           <= '{default: 8'h00};
            r_zeros_even     <= '0;
            r_zeros_odd      <= '0;
            r_ctl_count      <= '0;
            r_high_seen      <= 1'b0;
            r_cont_remaining <= '0;
            r_seq_length     <= '0;
            r_code_accum     <= '0;
            r_pending_bad    <= 1'b0;
            r_utf8_invalid   <= 1'b0;
            r_window_cut     <= 1'b0;
        end else if (w_in_acc) begin
            r_byte_count     <= n_byte_count;
            r_lead           <= n_lead;
            r_zeros_even     <= n_zeros_even;
            r_zeros_odd      <= n_zeros_odd;
            r_ctl_count      <= n_ctl_count;
            r_high_seen      <= n_high_seen;
            r_cont_remaining <= n_cont_remaining;
            r_seq_length     <= n_seq_length;
            r_code_accum     <= n_code_accum;
            r_pending_bad    <= n_pending_bad;
            r_utf8_invalid   <= n_utf8_invalid;
            r_window_cut     <= n_window_cut;
        end
    end

    // capture the end-of-file state for the verdict stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_done) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_snap_empty   <= i_empty_file;
            r_snap_bc      <= n_byte_count;
            r_snap_lead    <= n_lead;
            r_snap_ze      <= n_zeros_even;
            r_snap_zo      <= n_zeros_odd;
            r_snap_ctl     <= n_ctl_count;
            r_snap_high    <= n_high_seen;
            r_snap_invalid <= n_utf8_invalid;
            r_snap_open    <= (n_cont_remaining != 2'd0);
            r_snap_cut     <= n_window_cut;
        end
    end

    // verdict
    logic [16:0]       w_look;
    logic [CMP_W-1:0]  w_zeros, w_zo, w_ze, w_ctl100, w_look2;

    assign w_look   = (r_snap_bc < {1'b0, r_window}) ? r_snap_bc : {1'b0, r_window};
    assign w_ze     = CMP_W'(r_snap_ze);
    assign w_zo     = CMP_W'(r_snap_zo);
    assign w_zeros  = w_ze + w_zo;
    assign w_ctl100 = CMP_W'(r_snap_ctl) * CMP_W'(CTL_RATIO);
    assign w_look2  = CMP_W'({w_look, 1'b0});

    always_comb begin
        w_enc = ENC_UTF8;
        w_bom = BOM_NONE;
        if (r_snap_empty) begin
            w_enc = ENC_UNKNOWN;
        end else if (r_snap_bc >= 17'd3 && r_snap_lead[0] == BOM8_B0
                     && r_snap_lead[1] == BOM8_B1 && r_snap_lead[2] == BOM8_B2) begin
            w_enc = ENC_UTF8;
            w_bom = BOM_UTF8;
        end else if (r_snap_bc >= 17'd2 && r_snap_lead[0] == BOM16_FF
                     && r_snap_lead[1] == BOM16_FE) begin
            w_enc = ENC_UTF16LE;
            w_bom = BOM_UTF16;
        end else if (r_snap_bc >= 17'd2 && r_snap_lead[0] == BOM16_FE
                     && r_snap_lead[1] == BOM16_FF) begin
            w_enc = ENC_UTF16BE;
            w_bom = BOM_UTF16;
        end else if (w_zeros > CMP_W'(w_look[16:3])) begin
            if (w_zo > (w_ze << 3))      w_enc = ENC_UTF16LE;
            else if (w_ze > (w_zo << 3)) w_enc = ENC_UTF16BE;
            else                         w_enc = ENC_BINARY;
        end else if (w_zeros != '0) begin
            w_enc = ENC_BINARY;
        end else if (w_ctl100 > w_look2) begin
            w_enc = ENC_BINARY;
        end else if (!r_snap_high) begin
            w_enc = ENC_ASCII;
        end else if (r_snap_invalid) begin
            w_enc = ENC_LEGACY;
        end else if (r_snap_open) begin
            // a sequence left open counts as valid only if the window cut it
            w_enc = r_snap_cut ? ENC_UTF8 : ENC_LEGACY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_adv) begin
            r_enc <= w_enc;
            r_bom <= w_bom;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_encoding_code = r_enc;
    assign o_bom_length    = r_bom;

`ifndef NO_ASSERTIONS
    a_empty_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_snap_adv && r_snap_empty) |=>
            (o_out_valid && o_encoding_code == ENC_UNKNOWN && o_bom_length == BOM_NONE))
        else $error("empty-file item did not give an unknown verdict");

    a_bom_pairing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bom_length != BOM_NONE) |->
            ((o_encoding_code == ENC_UTF8 && o_bom_length == BOM_UTF8)
             || (o_encoding_code == ENC_UTF16LE && o_bom_length == BOM_UTF16)
             || (o_encoding_code == ENC_UTF16BE && o_bom_length == BOM_UTF16)))
        else $error("BOM length does not match the encoding");

    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_byte_count == '0 && r_cont_remaining == '0 && !r_utf8_invalid
                    && !r_window_cut && r_snap_valid))
        else $error("stream state not cleared after a verdict transfer");

    a_cont_within_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cont_remaining != 2'd0) |-> (r_cont_remaining <= r_seq_length))
        else $error("continuation count exceeds sequence length");
`endif

endmodule
